// File: hw/rtl/wasm_section_deframer_assert.svh
// ----------------------------------------------------------------------------
// wasm_section_deframer_assert.svh
// Assertion macros shared by the section deframer RTL.
// ----------------------------------------------------------------------------
`ifndef WASM_SECTION_DEFRAMER_ASSERT_SVH
`define WASM_SECTION_DEFRAMER_ASSERT_SVH

// Clocked check, switched off while reset is asserted
`define WSDF_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Clocked implication, switched off while reset is asserted
`define WSDF_ASSERT_IMP(label, pre, post, msg) \
    `WSDF_ASSERT(label, (pre) |-> (post), msg)

`endif

// File: hw/rtl/wsdf_pkg.sv
// ----------------------------------------------------------------------------
// wsdf_pkg
// Types and constants of the WebAssembly section deframer.
// ----------------------------------------------------------------------------
package wsdf_pkg;

    // Header: magic 00 61 73 6d, then version 1, both little-endian
    localparam logic [31:0] WASM_MAGIC    = 32'h6d73_6100;
    localparam logic [31:0] WASM_VERSION  = 32'h0000_0001;
    localparam logic [2:0]  HDR_LAST_IDX  = 3'd7;

    // LEB128 size field
    localparam logic [7:0]  LEB_DATA_MASK = 8'h7f;
    localparam int unsigned LEB_MORE_BIT  = 7;
    localparam logic [2:0]  LEB_MAX_BYTES = 3'd5;

    localparam logic [31:0] POS_MAX       = 32'hffff_ffff;

    typedef enum logic [2:0] {
        PH_HEADER  = 3'd0,
        PH_ID      = 3'd1,
        PH_SIZE    = 3'd2,
        PH_PAYLOAD = 3'd3,
        PH_IDLE    = 3'd4
    } t_phase;

    typedef enum logic [1:0] {
        KIND_DESC   = 2'd0,
        KIND_BADHDR = 2'd1,
        KIND_CLEAN  = 2'd2,
        KIND_TRUNC  = 2'd3
    } t_kind;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       module_start;
        logic       module_end;
    } t_in_item;

    typedef struct packed {
        t_kind       kind;
        logic [7:0]  id_byte;
        logic [31:0] payload_len;
        logic [31:0] payload_offset;
        logic [2:0]  size_field_bytes;
    } t_out_item;

    // Expected header byte at a given header position
    function automatic logic [7:0] header_expected(input logic [2:0] idx);
        logic [7:0] b;
        case (idx)
            3'd0:    b = WASM_MAGIC[7:0];
            3'd1:    b = WASM_MAGIC[15:8];
            3'd2:    b = WASM_MAGIC[23:16];
            3'd3:    b = WASM_MAGIC[31:24];
            3'd4:    b = WASM_VERSION[7:0];
            3'd5:    b = WASM_VERSION[15:8];
            3'd6:    b = WASM_VERSION[23:16];
            default: b = WASM_VERSION[31:24];
        endcase
        return b;
    endfunction

endpackage

// File: hw/rtl/wasm_section_deframer.sv
// Timing: an accepted input beat is held in the input register, then its
//   result is registered on the edge at which the byte leaves.
// Throughput: one byte per cycle; a byte whose result finds the output
//   register still full waits in the input register until that beat is taken.
// Reset: synchronous, active low; returns to header check at offset zero.
// ----------------------------------------------------------------------------
// wasm_section_deframer
// Checks the module header, decodes each section id and LEB128 size, skips
// the payload and emits one descriptor per section plus end/error reports.
// ----------------------------------------------------------------------------
`include "wasm_section_deframer_assert.svh"

module wasm_section_deframer (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  wsdf_pkg::t_in_item   i_in_data,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output wsdf_pkg::t_out_item  o_out_data
);
    import wsdf_pkg::*;

    // Input stage
    logic        r_in_valid;
    t_in_item    r_in;

    // Parser state
    t_phase      r_phase, n_phase;
    logic [2:0]  r_hidx,  n_hidx;
    logic [31:0] r_acc,   n_acc;
    logic [2:0]  r_cnt,   n_cnt;
    logic [7:0]  r_id,    n_id;
    logic [31:0] r_rem,   n_rem;
    logic [31:0] r_pos,   n_pos;

    // Output stage
    logic        r_out_valid;
    t_out_item   r_out;

    // State as seen by the current byte (module start restarts it)
    t_phase      w_phase;
    logic [2:0]  w_hidx;
    logic [31:0] w_acc;
    logic [2:0]  w_cnt;
    logic [7:0]  w_id;
    logic [31:0] w_rem;
    logic [31:0] w_pos;

    logic [7:0]  w_b;
    logic        w_last;
    logic        w_hdr_ok;
    logic [31:0] w_pos_next;
    logic [31:0] w_leb_part;
    logic [31:0] w_acc_new;
    logic [2:0]  w_cnt_new;
    logic        w_size_done;
    logic [31:0] w_rem_dec;

    logic        w_res_valid;
    t_out_item   w_res;
    logic        w_advance;

    // Restart the state on a module start byte
    always_comb begin
        w_b    = r_in.data_byte;
        w_last = r_in.module_end;
        if (r_in.module_start) begin
            w_phase = PH_HEADER;
            w_hidx  = '0;
            w_acc   = '0;
            w_cnt   = '0;
            w_id    = '0;
            w_rem   = '0;
            w_pos   = '0;
        end else begin
            w_phase = r_phase;
            w_hidx  = r_hidx;
            w_acc   = r_acc;
            w_cnt   = r_cnt;
            w_id    = r_id;
            w_rem   = r_rem;
            w_pos   = r_pos;
        end
    end

    // Shared datapath terms
    always_comb begin
        w_hdr_ok   = (w_b == header_expected(w_hidx));
        w_pos_next = (w_pos == POS_MAX) ? w_pos : w_pos + 32'd1;
        case (w_cnt)
            3'd0:    w_leb_part = {25'd0, w_b[6:0]};
            3'd1:    w_leb_part = {18'd0, w_b[6:0], 7'd0};
            3'd2:    w_leb_part = {11'd0, w_b[6:0], 14'd0};
            3'd3:    w_leb_part = {4'd0, w_b[6:0], 21'd0};
            3'd4:    w_leb_part = {w_b[3:0], 28'd0};
            default: w_leb_part = '0;
        endcase
        w_acc_new   = w_acc | w_leb_part;
        w_cnt_new   = w_cnt + 3'd1;
        w_size_done = !w_b[LEB_MORE_BIT] || (w_cnt_new >= LEB_MAX_BYTES);
        w_rem_dec   = (w_rem != '0) ? w_rem - 32'd1 : w_rem;
    end

    // Next state
    always_comb begin
        n_phase = w_phase;
        n_hidx  = w_hidx;
        n_acc   = w_acc;
        n_cnt   = w_cnt;
        n_id    = w_id;
        n_rem   = w_rem;
        n_pos   = w_pos_next;
        case (w_phase)
            PH_HEADER: begin
                if (!w_hdr_ok) begin
                    n_phase = PH_IDLE;
                end else if (w_hidx == HDR_LAST_IDX) begin
                    n_phase = w_last ? PH_IDLE : PH_ID;
                end else begin
                    n_hidx = w_hidx + 3'd1;
                    if (w_last) begin
                        n_phase = PH_IDLE;
                    end
                end
            end
            PH_ID: begin
                n_id    = w_b;
                n_acc   = '0;
                n_cnt   = '0;
                n_phase = w_last ? PH_IDLE : PH_SIZE;
            end
            PH_SIZE: begin
                n_acc = w_acc_new;
                n_cnt = w_cnt_new;
                if (w_size_done) begin
                    n_rem = w_acc_new;
                    if (w_last) begin
                        n_phase = PH_IDLE;
                    end else begin
                        n_phase = (w_acc_new == '0) ? PH_ID : PH_PAYLOAD;
                    end
                end else if (w_last) begin
                    n_phase = PH_IDLE;
                end
            end
            PH_PAYLOAD: begin
                n_rem = w_rem_dec;
                if (w_last) begin
                    n_phase = PH_IDLE;
                end else if (w_rem_dec == '0) begin
                    n_phase = PH_ID;
                end
            end
            default: begin
                n_phase = PH_IDLE;
            end
        endcase
    end

    // Result of the current byte
    always_comb begin
        w_res_valid = 1'b0;
        w_res       = '0;
        w_res.kind  = KIND_DESC;
        case (w_phase)
            PH_HEADER: begin
                if (!w_hdr_ok) begin
                    w_res_valid = 1'b1;
                    w_res.kind  = KIND_BADHDR;
                end else if (w_last) begin
                    w_res_valid = 1'b1;
                    w_res.kind  = (w_hidx == HDR_LAST_IDX) ? KIND_CLEAN : KIND_BADHDR;
                end
            end
            PH_ID: begin
                if (w_last) begin
                    w_res_valid = 1'b1;
                    w_res.kind  = KIND_TRUNC;
                end
            end
            PH_SIZE: begin
                if (w_size_done) begin
                    w_res_valid = 1'b1;
                    if (w_last) begin
                        w_res.kind = (w_acc_new == '0) ? KIND_CLEAN : KIND_TRUNC;
                    end else begin
                        w_res.kind             = KIND_DESC;
                        w_res.id_byte          = w_id;
                        w_res.payload_len      = w_acc_new;
                        w_res.payload_offset   = w_pos_next;
                        w_res.size_field_bytes = w_cnt_new;
                    end
                end else if (w_last) begin
                    w_res_valid = 1'b1;
                    w_res.kind  = KIND_TRUNC;
                end
            end
            PH_PAYLOAD: begin
                if (w_last) begin
                    w_res_valid = 1'b1;
                    w_res.kind  = (w_rem_dec == '0) ? KIND_CLEAN : KIND_TRUNC;
                end
            end
            default: begin
                w_res_valid = 1'b0;
            end
        endcase
    end

    // Advance the held byte unless its result has nowhere to go
    assign w_advance  = r_in_valid && (!w_res_valid || !r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || w_advance;

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_phase     <= PH_HEADER;
            r_hidx      <= '0;
            r_acc       <= '0;
            r_cnt       <= '0;
            r_id        <= '0;
            r_rem       <= '0;
            r_pos       <= '0;
        end else begin
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (w_advance && w_res_valid) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (w_advance) begin
                r_phase <= n_phase;
                r_hidx  <= n_hidx;
                r_acc   <= n_acc;
                r_cnt   <= n_cnt;
                r_id    <= n_id;
                r_rem   <= n_rem;
                r_pos   <= n_pos;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in <= i_in_data;
        end
        if (w_advance && w_res_valid) begin
            r_out <= w_res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // Checks
    `WSDF_ASSERT_IMP(a_desc_len, o_out_valid && (o_out_data.kind == KIND_DESC),
        (o_out_data.size_field_bytes != 3'd0) && (o_out_data.size_field_bytes <= LEB_MAX_BYTES),
        "descriptor with bad size field length")
    `WSDF_ASSERT_IMP(a_report_zero, o_out_valid && (o_out_data.kind != KIND_DESC),
        (o_out_data.size_field_bytes == 3'd0) && (o_out_data.id_byte == 8'd0),
        "end or error report carries section fields")
    `WSDF_ASSERT_IMP(a_size_cnt, r_phase == PH_SIZE, r_cnt < LEB_MAX_BYTES,
        "size field ran past its byte limit")
    `WSDF_ASSERT_IMP(a_payload_rem, r_phase == PH_PAYLOAD, r_rem != '0,
        "payload phase with nothing left to skip")
    `WSDF_ASSERT(a_hold_byte, r_in_valid && !w_advance |=> r_in_valid,
        "held byte dropped while stalled")

endmodule
